FILE: rtl/e2c_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_pkg: shared types and constants for the epoch to civil date converter
// Reciprocal multipliers for the constant divisions, calendar offsets and
// the month start table.
// ----------------------------------------------------------------------------
package e2c_pkg;

    // Pipeline depth, input register to output register
    localparam int unsigned NUM_STAGES = 7;

    // days = (epoch >> 7) / 675, exact for any 25-bit dividend
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam int unsigned DAY_SHIFT     = 35;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;

    // Shift of the day count to 0000-03-01 and era handling
    localparam logic [19:0] SHIFT_TO_0300 = 20'd719468;
    localparam logic [19:0] ERA5_START    = 20'd730485;   // 5 * 146097
    localparam logic [19:0] ERA4_START    = 20'd584388;   // 4 * 146097
    localparam logic [2:0]  ERA_LOW       = 3'd4;
    localparam logic [2:0]  ERA_HIGH      = 3'd5;

    // de / 1460 = (de >> 2) / 365
    localparam logic [16:0] D1460_RECIP   = 17'd91930;
    localparam int unsigned D1460_SHIFT   = 25;
    localparam logic [17:0] CENT_DAYS1    = 18'd36524;
    localparam logic [17:0] CENT_DAYS2    = 18'd73048;
    localparam logic [17:0] CENT_DAYS3    = 18'd109572;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;

    // n / 365
    localparam logic [18:0] D365_RECIP    = 19'd367720;
    localparam int unsigned D365_SHIFT    = 27;

    // (5 * doy + 2) / 153
    localparam logic [11:0] D153_RECIP    = 12'd3427;
    localparam int unsigned D153_SHIFT    = 19;

    // Time of day: sod / 3600 = (sod >> 4) / 225, rem / 60 = (rem >> 2) / 15
    localparam logic [13:0] D225_RECIP    = 14'd9321;
    localparam int unsigned D225_SHIFT    = 21;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [10:0] D15_RECIP     = 11'd1093;
    localparam int unsigned D15_SHIFT     = 14;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;

    localparam logic [11:0] YEARS_PER_ERA = 12'd400;
    localparam logic [3:0]  MP_JANUARY    = 4'd10;

    // Split stage results handed to the date and time-of-day pipelines
    typedef struct packed {
        logic [17:0] de;    // day of era, 0..146096
        logic [2:0]  era;   // 400-year era
        logic [16:0] sod;   // second of day
    } e2c_split_t;

    // First day of each March-based month: (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/e2c_split.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_split: first two pipeline stages
// Divide the timestamp into days and second of day, shift the day count to
// a March-based origin and reduce it to era and day of era.
// ----------------------------------------------------------------------------
module e2c_split (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [31:0]         epoch,
    output e2c_pkg::e2c_split_t      split
);

    logic [50:0] day_prod;
    logic [15:0] days_reg;
    logic [15:0] days_next;
    logic [16:0] lo_reg;

    logic [31:0] day_secs;
    logic [19:0] z;
    logic        era5;
    logic [19:0] de_wide;
    e2c_pkg::e2c_split_t split_reg;
    e2c_pkg::e2c_split_t split_next;

    // Stage 1: days by reciprocal multiply
    always_comb
    begin
        day_prod  = 51'(epoch[31:7]) * 51'(e2c_pkg::DAY_RECIP);
        days_next = day_prod[e2c_pkg::DAY_SHIFT +: 16];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            days_reg <= days_next;
            lo_reg   <= epoch[16:0];
        end
    end

    // Stage 2: second of day, era and day of era
    always_comb
    begin
        day_secs         = 32'(days_reg) * e2c_pkg::SECS_PER_DAY;
        z                = 20'(days_reg) + e2c_pkg::SHIFT_TO_0300;
        era5             = (z >= e2c_pkg::ERA5_START);
        de_wide          = z - (era5 ? e2c_pkg::ERA5_START : e2c_pkg::ERA4_START);
        split_next.sod   = lo_reg - day_secs[16:0];
        split_next.de    = de_wide[17:0];
        split_next.era   = era5 ? e2c_pkg::ERA_HIGH : e2c_pkg::ERA_LOW;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            split_reg <= split_next;
        end
    end

    assign split = split_reg;

endmodule
`default_nettype wire

FILE: rtl/e2c_date.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_date: five date stages
// Turn era and day of era into year, month and day of month.
// ----------------------------------------------------------------------------
module e2c_date (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [17:0] de,
    input  wire logic [2:0]  era,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day
);

    // Stage 3: day count with leap days removed
    logic [32:0] q1460_prod;
    logic [7:0]  q1460;
    logic [2:0]  cents;
    logic        last_day;
    logic [17:0] n_next;
    logic [17:0] n_reg;
    logic [17:0] de3_reg;
    logic [2:0]  era3_reg;

    always_comb
    begin
        q1460_prod = 33'(de[17:2]) * 33'(e2c_pkg::D1460_RECIP);
        q1460      = q1460_prod[e2c_pkg::D1460_SHIFT +: 8];
        cents      = 3'(de >= e2c_pkg::CENT_DAYS1) + 3'(de >= e2c_pkg::CENT_DAYS2)
                   + 3'(de >= e2c_pkg::CENT_DAYS3) + 3'(de >= e2c_pkg::ERA_LAST_DAY);
        last_day   = (de == e2c_pkg::ERA_LAST_DAY);
        n_next     = de - 18'(q1460) + 18'(cents) - 18'(last_day);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg    <= n_next;
            de3_reg  <= de;
            era3_reg <= era;
        end
    end

    // Stage 4: year of era
    logic [36:0] ye_prod;
    logic [8:0]  ye_next;
    logic [8:0]  ye4_reg;
    logic [17:0] de4_reg;
    logic [2:0]  era4_reg;

    always_comb
    begin
        ye_prod = 37'(n_reg) * 37'(e2c_pkg::D365_RECIP);
        ye_next = ye_prod[e2c_pkg::D365_SHIFT +: 9];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ye4_reg  <= ye_next;
            de4_reg  <= de3_reg;
            era4_reg <= era3_reg;
        end
    end

    // Stage 5: day of March-based year
    logic [1:0]  ye_cent;
    logic [17:0] year_days;
    logic [17:0] doy_wide;
    logic [8:0]  doy5_reg;
    logic [8:0]  ye5_reg;
    logic [2:0]  era5_reg;

    always_comb
    begin
        ye_cent   = 2'(ye4_reg >= 9'd100) + 2'(ye4_reg >= 9'd200) + 2'(ye4_reg >= 9'd300);
        year_days = 18'(ye4_reg) * 18'd365 + 18'(ye4_reg[8:2]) - 18'(ye_cent);
        doy_wide  = de4_reg - year_days;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            doy5_reg <= doy_wide[8:0];
            ye5_reg  <= ye4_reg;
            era5_reg <= era4_reg;
        end
    end

    // Stage 6: March-based month
    logic [10:0] mp_arg;
    logic [22:0] mp_prod;
    logic [3:0]  mp6_reg;
    logic [8:0]  doy6_reg;
    logic [8:0]  ye6_reg;
    logic [2:0]  era6_reg;

    always_comb
    begin
        mp_arg  = 11'(doy5_reg) * 11'd5 + 11'd2;
        mp_prod = 23'(mp_arg) * 23'(e2c_pkg::D153_RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mp6_reg  <= mp_prod[e2c_pkg::D153_SHIFT +: 4];
            doy6_reg <= doy5_reg;
            ye6_reg  <= ye5_reg;
            era6_reg <= era5_reg;
        end
    end

    // Stage 7: civil month, day and year
    logic [8:0]  dom_wide;
    logic [3:0]  month_next;
    logic [11:0] year_next;
    logic [11:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;

    always_comb
    begin
        dom_wide   = doy6_reg - e2c_pkg::month_start(mp6_reg) + 9'd1;
        month_next = (mp6_reg < e2c_pkg::MP_JANUARY) ? mp6_reg + 4'd3 : mp6_reg - 4'd9;
        year_next  = 12'(ye6_reg) + 12'(era6_reg) * e2c_pkg::YEARS_PER_ERA
                   + 12'(month_next <= 4'd2);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            year_reg  <= year_next;
            month_reg <= month_next;
            day_reg   <= dom_wide[4:0];
        end
    end

    assign year  = year_reg;
    assign month = month_reg;
    assign day   = day_reg;

endmodule
`default_nettype wire

FILE: rtl/e2c_tod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_tod: five time-of-day stages
// Split the second of day into hour, minute and second, timed to match the
// date stages.
// ----------------------------------------------------------------------------
module e2c_tod (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [16:0] sod,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second
);

    // Stage 3: hour
    logic [26:0] hr_prod;
    logic [4:0]  hr3_reg;
    logic [16:0] sod3_reg;

    assign hr_prod = 27'(sod[16:4]) * 27'(e2c_pkg::D225_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hr3_reg  <= hr_prod[e2c_pkg::D225_SHIFT +: 5];
            sod3_reg <= sod;
        end
    end

    // Stage 4: second of hour
    logic [16:0] soh_wide;
    logic [11:0] soh4_reg;
    logic [4:0]  hr4_reg;

    assign soh_wide = sod3_reg - 17'(hr3_reg) * e2c_pkg::SECS_PER_HOUR;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            soh4_reg <= soh_wide[11:0];
            hr4_reg  <= hr3_reg;
        end
    end

    // Stage 5: minute
    logic [20:0] mn_prod;
    logic [5:0]  mn5_reg;
    logic [11:0] soh5_reg;
    logic [4:0]  hr5_reg;

    assign mn_prod = 21'(soh4_reg[11:2]) * 21'(e2c_pkg::D15_RECIP);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mn5_reg  <= mn_prod[e2c_pkg::D15_SHIFT +: 6];
            soh5_reg <= soh4_reg;
            hr5_reg  <= hr4_reg;
        end
    end

    // Stage 6: second
    logic [11:0] sec_wide;
    logic [5:0]  sec6_reg;
    logic [5:0]  mn6_reg;
    logic [4:0]  hr6_reg;

    assign sec_wide = soh5_reg - 12'(mn5_reg) * e2c_pkg::SECS_PER_MIN;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec6_reg <= sec_wide[5:0];
            mn6_reg  <= mn5_reg;
            hr6_reg  <= hr5_reg;
        end
    end

    // Stage 7: align with the date output register
    logic [4:0] hour_reg;
    logic [5:0] minute_reg;
    logic [5:0] second_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hour_reg   <= hr6_reg;
            minute_reg <= mn6_reg;
            second_reg <= sec6_reg;
        end
    end

    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule
`default_nettype wire

FILE: rtl/epoch_to_civil_date_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_to_civil_date_time: Unix seconds to UTC civil date and time
// Seven-stage pipeline converting a 32-bit timestamp to year, month, day,
// hour, minute and second of the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------
//  input     in_valid, in_stall   epoch[31:0]
//  output    out_valid, out_stall year[11:0] month[3:0] day[4:0]
//                                 hour[4:0] minute[5:0] second[5:0]
//
//  Throughput is one transaction per cycle while no stalled result holds
//  the output; reciprocal multiplies replace each constant division.
//  Reset clears only the stage valid bits; the datapath registers have no reset.
//  A stalled output transaction freezes the whole pipeline, so in_stall
//  follows out_stall while the output register holds a result.
// ----------------------------------------------------------------------------
module epoch_to_civil_date_time (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] epoch,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [11:0]      year,
    output logic [3:0]       month,
    output logic [4:0]       day,
    output logic [4:0]       hour,
    output logic [5:0]       minute,
    output logic [5:0]       second
);

    logic                              en;
    logic [e2c_pkg::NUM_STAGES-1:0]    valid_reg;
    logic [e2c_pkg::NUM_STAGES-1:0]    valid_next;
    e2c_pkg::e2c_split_t               split;

    // Advance every stage together unless the output holds a stalled result
    assign en       = !(valid_reg[e2c_pkg::NUM_STAGES-1] && out_stall);
    assign in_stall = !en;

    // Valid bits ride alongside the data stages
    assign valid_next = {valid_reg[e2c_pkg::NUM_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // Stages 1-2: days, second of day, era
    e2c_split u_split (
        .clk   (clk),
        .en    (en),
        .epoch (epoch),
        .split (split)
    );

    // Stages 3-7: calendar date
    e2c_date u_date (
        .clk   (clk),
        .en    (en),
        .de    (split.de),
        .era   (split.era),
        .year  (year),
        .month (month),
        .day   (day)
    );

    // Stages 3-7: time of day
    e2c_tod u_tod (
        .clk    (clk),
        .en     (en),
        .sod    (split.sod),
        .hour   (hour),
        .minute (minute),
        .second (second)
    );

    assign out_valid = valid_reg[e2c_pkg::NUM_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/e2c_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2c_chk: port checker for the epoch to civil date converter
// Watches the handshakes and the ranges of delivered results.
// ----------------------------------------------------------------------------
module e2c_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [11:0] year,
    input wire logic [3:0]  month,
    input wire logic [4:0]  day,
    input wire logic [4:0]  hour,
    input wire logic [5:0]  minute,
    input wire logic [5:0]  second
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(year) && $stable(month)
            && $stable(day) && $stable(hour) && $stable(minute) && $stable(second))
        else $error("stalled output transaction changed");

    // Back-pressure only comes from a stalled full output
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A transaction taken while out_stall then stays low shows up as out_valid
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall ##1 !out_stall [*6] |=> out_valid)
        else $error("transaction lost in pipeline");

    // Date fields in range
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1
            && month <= 4'd12 && day >= 5'd1)
        else $error("date field out of range");

    // Time fields in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("time field out of range");

endmodule

bind epoch_to_civil_date_time e2c_chk u_e2c_chk (.*);
`default_nettype wire

FILE: sim/tb_epoch_to_civil_date_time.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_epoch_to_civil_date_time: self-checking bench for the epoch converter
// Feeds 32-bit Unix timestamps through the valid/stall input channel and
// checks every output transaction against a typed or predicted calendar date.
// Directed probes come first, then randomized timestamps.
// ----------------------------------------------------------------------------
module tb_epoch_to_civil_date_time;

    // Calendar constants of the predictor
    localparam int unsigned DAY_SECS   = 86400;
    localparam int unsigned HOUR_SECS  = 3600;
    localparam int unsigned MIN_SECS   = 60;
    localparam int unsigned MARCH_BASE = 719468;   // 1970-01-01 counted from 0000-03-01
    localparam int unsigned ERA_DAYS   = 146097;   // days in 400 Gregorian years
    localparam int unsigned LAST_DAY   = 49709;    // last whole day below 2^32 seconds

    localparam int RANDOM_ITEMS  = 600;
    localparam int IDLE_PCT      = 31;
    // Sender keeps offering without gaps for this window of random items
    localparam int QUIET_FIRST   = 380;
    localparam int QUIET_LAST    = 500;
    // Receiver windows, counted in its own cycles after reset
    localparam int HOLD_FIRST    = 250;
    localparam int HOLD_CYCLES   = 64;
    localparam int OPEN_FIRST    = 600;
    localparam int OPEN_CYCLES   = 200;
    localparam int DRAIN_CYCLES  = e2c_pkg::NUM_STAGES + 8;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } civil_t;

    // One directed row: timestamp, whether the expected date is written in,
    // and that date
    typedef struct {
        logic [31:0] secs;
        bit          typed;
        civil_t      want;
    } probe_t;

    localparam int NUM_PROBES = 20;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] epoch;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;

    civil_t dates_due[$];   // expected dates, oldest first
    int     errors_seen;

    probe_t probes [NUM_PROBES] = '{
        // Range extremes and widely known instants, expected date typed in
        '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
        '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'd946684800,  1'b1, '{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'd1000000000, 1'b1, '{12'd2001, 4'd9,  5'd9,  5'd1,  6'd46, 6'd40}},
        '{32'h7FFFFFFF,   1'b1, '{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7}},
        '{32'h80000000,   1'b1, '{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd8}},
        // Day rollover
        '{32'd86400,      1'b0, '0},
        // Leap day of an ordinary leap year and the last second of that year
        '{32'd68169600,   1'b0, '0},
        '{32'd94694399,   1'b0, '0},
        // Leap day of a 400-year leap century, then the era boundary on March 1
        '{32'd951782400,  1'b0, '0},
        '{32'd951868799,  1'b0, '0},
        '{32'd951868800,  1'b0, '0},
        // Non-leap century: February 28 straight into March 1 of 2100
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        // Alternating and half-word bit patterns
        '{32'hAAAAAAAA,   1'b0, '0},
        '{32'h55555555,   1'b0, '0},
        '{32'hFFFF0000,   1'b0, '0},
        '{32'h0000FFFF,   1'b0, '0}
    };

    epoch_to_civil_date_time u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .epoch     (epoch),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .year      (year),
        .month     (month),
        .day       (day),
        .hour      (hour),
        .minute    (minute),
        .second    (second)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: split seconds into whole days and second of day, move the
    // day count onto a March-based calendar and break it into 400-year eras.
    // ------------------------------------------------------------------------
    function automatic civil_t civil_of(input logic [31:0] secs);
        int unsigned day_count;
        int unsigned sec_of_day;
        int unsigned shifted;
        int unsigned era_idx;
        int unsigned day_of_era;
        int unsigned year_of_era;
        int unsigned day_of_year;
        int unsigned month_idx;
        int unsigned month_num;
        civil_t      date;
        day_count   = secs / DAY_SECS;
        sec_of_day  = secs % DAY_SECS;
        shifted     = day_count + MARCH_BASE;
        era_idx     = shifted / ERA_DAYS;
        day_of_era  = shifted - era_idx * ERA_DAYS;
        // Leap-day corrections within the era, then whole years
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4
                                    - year_of_era / 100);
        month_idx   = (5 * day_of_year + 2) / 153;          // 0 is March
        month_num   = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
        date.day    = 5'(day_of_year - (153 * month_idx + 2) / 5 + 1);
        date.month  = 4'(month_num);
        // January and February belong to the next civil year
        date.year   = 12'(year_of_era + era_idx * 400 + ((month_num <= 2) ? 1 : 0));
        date.hour   = 5'(sec_of_day / HOUR_SECS);
        date.minute = 6'((sec_of_day % HOUR_SECS) / MIN_SECS);
        date.second = 6'(sec_of_day % MIN_SECS);
        return date;
    endfunction

    // ------------------------------------------------------------------------
    // Input side: optionally idle first, then offer one transaction and hold
    // it until accepted. The expectation is queued at the accepting edge.
    // valid is only changed once per edge: an idle lowers it, the offer
    // raises it at a later edge.
    // ------------------------------------------------------------------------
    task automatic offer_stamp(input logic [31:0] secs, input civil_t want,
                               input bit idle_ok);
        if (idle_ok && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch    <= secs;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        dates_due.push_back(want);
    endtask

    // Random timestamp: uniform in 45 percent of picks, the rest packed around day edges,
    // the top of the range and the first days after 1970
    function automatic logic [31:0] pick_stamp();
        int unsigned  sel;
        logic [31:0]  secs;
        sel = $urandom_range(99);
        if (sel < 45)
        begin
            secs = $urandom;
        end
        else if (sel < 75)
        begin
            secs = $urandom_range(0, LAST_DAY) * DAY_SECS;
            case ($urandom_range(2))
                0:       secs = secs + DAY_SECS - 1;
                1:       secs = secs + $urandom_range(0, 3);
                default: secs = secs;
            endcase
        end
        else if (sel < 88)
        begin
            secs = 32'hFFFFFFFF - $urandom_range(0, 400000);
        end
        else
        begin
            secs = $urandom_range(0, 400000);
        end
        return secs;
    endfunction

    // Drive reset, the directed table, then the random stream
    initial
    begin
        logic [31:0] secs;
        civil_t      want;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        epoch       = '0;
        errors_seen = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed probes: use the typed date where one is given
        for (int i = 0; i < NUM_PROBES; i++)
        begin
            want = probes[i].typed ? probes[i].want : civil_of(probes[i].secs);
            offer_stamp(probes[i].secs, want, 1'b1);
        end

        // Random stream, with a quiet window of back-to-back offers
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            secs = pick_stamp();
            offer_stamp(secs, civil_of(secs), !(i >= QUIET_FIRST && i < QUIET_LAST));
        end
        in_valid <= 1'b0;

        // Drain: wait for every outstanding date, then allow the pipe to settle
        while (dates_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors_seen == 0)
            $display("tb_epoch_to_civil_date_time: clean");
        else
            $display("tb_epoch_to_civil_date_time: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Output side: random stall, one long hold-off that backs the pipeline up
    // into in_stall while the sender keeps offering, and a long open window.
    // ------------------------------------------------------------------------
    initial
    begin
        int rx_cycle;
        out_stall = 1'b0;
        rx_cycle  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HOLD_FIRST && rx_cycle < HOLD_FIRST + HOLD_CYCLES)
                out_stall <= 1'b1;
            else if (rx_cycle >= OPEN_FIRST && rx_cycle < OPEN_FIRST + OPEN_CYCLES)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors_seen++;
        end
    endtask

    // Compare each accepted output transaction with the oldest expected date.
    // Sampling at the edge sees the values that held just before it.
    always @(posedge clk)
    begin
        civil_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (dates_due.size() == 0)
            begin
                $error("unexpected output transaction: %0d-%0d-%0d %0d:%0d:%0d",
                       year, month, day, hour, minute, second);
                errors_seen++;
            end
            else
            begin
                want = dates_due.pop_front();
                check_field("year",   32'(want.year),   32'(year));
                check_field("month",  32'(want.month),  32'(month));
                check_field("day",    32'(want.day),    32'(day));
                check_field("hour",   32'(want.hour),   32'(hour));
                check_field("minute", 32'(want.minute), 32'(minute));
                check_field("second", 32'(want.second), 32'(second));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #1000000;
        $display("tb_epoch_to_civil_date_time: errors");
        $finish;
    end

endmodule
`default_nettype wire
